>>> rtl/core/vsab_pkg.sv
// ----------------------------------------------------------------------------
// vsab_pkg: shared constants for the vital sign alarm beeper
// Default widths, register indexes, register reset values and the buzzer
// half-period codes chosen by the alarm priority encoder.
// ----------------------------------------------------------------------------
package vsab_pkg;

	// Default build widths.
	localparam int ADC_BITS_DEF   = 12;
	localparam int TIMER_BITS_DEF = 16;

	// Configuration port shape.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Register widths.
	localparam int PULSE_W    = 8;
	localparam int LIMIT_W    = 12;
	localparam int PERIOD_W   = 16;
	localparam int HALF_W     = 10;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_ALERT_LEVEL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_HIGH_COUNT   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_LOW_COUNT    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_PERIOD_MS    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CRY_HOLD_MS       = 3'd4;

	// Register reset values.
	localparam logic [PULSE_W-1:0]  RST_PULSE_ALERT_LEVEL = 8'd100;
	localparam logic [LIMIT_W-1:0]  RST_TEMP_HIGH_COUNT   = 12'd893;
	localparam logic [LIMIT_W-1:0]  RST_TEMP_LOW_COUNT    = 12'd869;
	localparam logic [PERIOD_W-1:0] RST_TEMP_PERIOD_MS    = 16'd2000;
	localparam logic [PERIOD_W-1:0] RST_CRY_HOLD_MS       = 16'd3000;

	// Pulse mapping: base + sample * span / full scale.
	localparam logic [PULSE_W-1:0] PULSE_BASE = 8'd40;
	localparam logic [PULSE_W-1:0] PULSE_SPAN = 8'd140;

	// Buzzer half-periods in milliseconds, highest priority first.
	localparam logic [HALF_W-1:0] HALF_CRY_PULSE = 10'd80;
	localparam logic [HALF_W-1:0] HALF_PULSE     = 10'd150;
	localparam logic [HALF_W-1:0] HALF_CRY       = 10'd400;
	localparam logic [HALF_W-1:0] HALF_HOT       = 10'd1000;
	localparam logic [HALF_W-1:0] HALF_COLD      = 10'd600;
	localparam logic [HALF_W-1:0] HALF_SILENT    = 10'd0;

endpackage

>>> rtl/core/vsab_pulse_map.sv
// ----------------------------------------------------------------------------
// vsab_pulse_map: knob sample to simulated pulse rate
// Computes base + floor(sample * span / (2^ADC_BITS - 1)) with a shift
// estimate and a single compare-and-correct step instead of a divider.
// ----------------------------------------------------------------------------
module vsab_pulse_map import vsab_pkg::*; #(
	parameter int ADC_BITS = ADC_BITS_DEF
) (
	input  logic [ADC_BITS-1:0] knob,
	output logic [PULSE_W-1:0]  pulse
);

	localparam int P_W = ADC_BITS + PULSE_W;
	localparam logic [P_W-1:0] FULL_SCALE = P_W'((1 << ADC_BITS) - 1);

	logic [P_W-1:0]     prod;
	logic [PULSE_W-1:0] est;
	logic [P_W-1:0]     est_ext;
	logic [P_W-1:0]     est_times_fs;
	logic [P_W-1:0]     rem;
	logic [PULSE_W-1:0] quot;

	// The quotient is below 2^ADC_BITS, so the shift estimate is either exact
	// or one short; the remainder tells which.
	always_comb begin
		prod         = P_W'(knob) * P_W'(PULSE_SPAN);
		est          = PULSE_W'(prod >> ADC_BITS);
		est_ext      = P_W'(est);
		est_times_fs = (est_ext << ADC_BITS) - est_ext;
		rem          = prod - est_times_fs;
		quot         = (rem >= FULL_SCALE) ? est + PULSE_W'(1) : est;
		pulse        = PULSE_BASE + quot;
	end

endmodule

>>> rtl/core/vital_sign_alarm_beeper.sv
// ----------------------------------------------------------------------------
// vital_sign_alarm_beeper: infant monitor alarm and buzzer driver
// One input item per millisecond tick; produces the pulse reading, the alarm
// flags, the selected buzzer half-period and the buzzer pin level per tick.
// ----------------------------------------------------------------------------
// Usage:
// Each item on the s_axis channel is one millisecond tick. Its tdata carries
// the microphone comparator bit, the pulse knob sample and the temperature
// sample. Every accepted item yields exactly one result item on m_axis.
// The item is first captured in an input register. Once the output register
// is free or being emptied, the pulse mapping, the temperature and crying
// timers, the priority encoder and the buzzer toggle logic are evaluated in
// one pass, the timer state is updated and the result is loaded into the
// output register, from which it is shown on m_axis. While the receiver keeps
// m_axis_tready high, a new item can be accepted every cycle, so throughput
// is one item per clock.
// When the receiver stalls, the result waits in the output register, the
// next item is still taken into the input register, and only then does
// s_axis_tready drop until the output register is drained.
// Reset clears the pipeline valids, all timers and the state flags, and loads the
// register defaults. Configuration writes on cfg_we take effect at once and
// should only be issued while no item is in flight.
// ----------------------------------------------------------------------------
module vital_sign_alarm_beeper import vsab_pkg::*; #(
	parameter int ADC_BITS   = ADC_BITS_DEF,
	parameter int TIMER_BITS = TIMER_BITS_DEF,
	localparam int IN_W      = ((2 * ADC_BITS + 1 + 7) / 8) * 8,
	localparam int OUT_W     = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// Fields from bit 0: mic_level, knob_sample, thermo_sample, zero fill.
	input  logic [IN_W-1:0]       s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// Fields from bit 0: pulse_value, pulse_alert, cry_alert, hot_alert,
	// cold_alert, beep_half_period, buzzer_drive, zero fill.
	output logic [OUT_W-1:0]      m_axis_tdata,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// Comparison widths wide enough for both operands.
	localparam int LIM_CMP_W = (ADC_BITS > LIMIT_W) ? ADC_BITS : LIMIT_W;
	localparam int TMR_CMP_W = (TIMER_BITS > PERIOD_W) ? TIMER_BITS : PERIOD_W;
	localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

	// Configuration registers.
	logic [PULSE_W-1:0]  pulse_level_q;
	logic [LIMIT_W-1:0]  temp_high_q;
	logic [LIMIT_W-1:0]  temp_low_q;
	logic [PERIOD_W-1:0] temp_period_q;
	logic [PERIOD_W-1:0] cry_hold_q;

	// Input stage.
	logic                in_valid_s1;
	logic                mic_s1;
	logic [ADC_BITS-1:0] knob_s1;
	logic [ADC_BITS-1:0] thermo_s1;

	// Tick state.
	logic [TIMER_BITS-1:0] temp_elapsed_q;
	logic [TIMER_BITS-1:0] cry_elapsed_q;
	logic [TIMER_BITS-1:0] buzz_elapsed_q;
	logic                  hot_q;
	logic                  cold_q;
	logic                  cry_q;
	logic                  buzz_q;

	// Output register.
	logic               out_valid_q;
	logic [PULSE_W-1:0] pulse_q;
	logic               pulse_alert_q;
	logic [HALF_W-1:0]  half_q;

	// Single-pass results.
	logic                  advance;
	logic [PULSE_W-1:0]    pulse;
	logic                  pulse_hi;
	logic [TIMER_BITS-1:0] temp_inc;
	logic [TIMER_BITS-1:0] cry_inc;
	logic [TIMER_BITS-1:0] buzz_inc;
	logic                  temp_due;
	logic                  hot_nx;
	logic                  cold_nx;
	logic                  cry_start;
	logic [TIMER_BITS-1:0] cry_elapsed_nx;
	logic                  cry_nx;
	logic [HALF_W-1:0]     half;
	logic                  buzz_due;
	logic [TIMER_BITS-1:0] temp_elapsed_nx;
	logic [TIMER_BITS-1:0] buzz_elapsed_nx;
	logic                  buzz_nx;

	// The input register moves on whenever the output register is free or
	// being emptied in this cycle.
	assign advance       = in_valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !in_valid_s1 || advance;

	vsab_pulse_map #(
		.ADC_BITS (ADC_BITS)
	) u_pulse_map (
		.knob  (knob_s1),
		.pulse (pulse)
	);

	always_comb begin
		// All elapsed counters saturate rather than wrap.
		temp_inc = temp_elapsed_q + TIMER_BITS'(temp_elapsed_q != TIMER_MAX);
		cry_inc  = cry_elapsed_q + TIMER_BITS'(cry_elapsed_q != TIMER_MAX);
		buzz_inc = buzz_elapsed_q + TIMER_BITS'(buzz_elapsed_q != TIMER_MAX);

		pulse_hi = pulse >= pulse_level_q;

		// Temperature is resampled once the period has been exceeded.
		temp_due = TMR_CMP_W'(temp_inc) > TMR_CMP_W'(temp_period_q);
		if (temp_due) begin
			hot_nx          = LIM_CMP_W'(thermo_s1) > LIM_CMP_W'(temp_high_q);
			cold_nx         = LIM_CMP_W'(thermo_s1) < LIM_CMP_W'(temp_low_q);
			temp_elapsed_nx = '0;
		end else begin
			hot_nx          = hot_q;
			cold_nx         = cold_q;
			temp_elapsed_nx = temp_inc;
		end

		// A new cry restarts the hold timer; the hold ends once it is exceeded.
		cry_start      = !mic_s1 && !cry_q;
		cry_elapsed_nx = cry_start ? '0 : cry_inc;
		cry_nx         = (cry_q || cry_start) &&
			!(TMR_CMP_W'(cry_elapsed_nx) > TMR_CMP_W'(cry_hold_q));

		// Priority encoder for the buzzer half-period.
		if (cry_nx && pulse_hi) begin
			half = HALF_CRY_PULSE;
		end else if (pulse_hi) begin
			half = HALF_PULSE;
		end else if (cry_nx) begin
			half = HALF_CRY;
		end else if (hot_nx) begin
			half = HALF_HOT;
		end else if (cold_nx) begin
			half = HALF_COLD;
		end else begin
			half = HALF_SILENT;
		end

		// Silence forces the pin low while its timer keeps running.
		buzz_due = buzz_inc >= TIMER_BITS'(half);
		if (half == HALF_SILENT) begin
			buzz_nx         = 1'b0;
			buzz_elapsed_nx = buzz_inc;
		end else if (buzz_due) begin
			buzz_nx         = !buzz_q;
			buzz_elapsed_nx = '0;
		end else begin
			buzz_nx         = buzz_q;
			buzz_elapsed_nx = buzz_inc;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_level_q <= RST_PULSE_ALERT_LEVEL;
			temp_high_q   <= RST_TEMP_HIGH_COUNT;
			temp_low_q    <= RST_TEMP_LOW_COUNT;
			temp_period_q <= RST_TEMP_PERIOD_MS;
			cry_hold_q    <= RST_CRY_HOLD_MS;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_PULSE_ALERT_LEVEL: pulse_level_q <= cfg_data[PULSE_W-1:0];
				REG_TEMP_HIGH_COUNT:   temp_high_q   <= cfg_data[LIMIT_W-1:0];
				REG_TEMP_LOW_COUNT:    temp_low_q    <= cfg_data[LIMIT_W-1:0];
				REG_TEMP_PERIOD_MS:    temp_period_q <= cfg_data[PERIOD_W-1:0];
				REG_CRY_HOLD_MS:       cry_hold_q    <= cfg_data[PERIOD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Input stage valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			in_valid_s1 <= s_axis_tvalid;
		end
	end

	// Input stage payload.
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			mic_s1    <= s_axis_tdata[0];
			knob_s1   <= s_axis_tdata[ADC_BITS:1];
			thermo_s1 <= s_axis_tdata[2*ADC_BITS:ADC_BITS+1];
		end
	end

	// Tick state and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_elapsed_q <= '0;
			cry_elapsed_q  <= '0;
			buzz_elapsed_q <= '0;
			hot_q          <= 1'b0;
			cold_q         <= 1'b0;
			cry_q          <= 1'b0;
			buzz_q         <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (advance) begin
				temp_elapsed_q <= temp_elapsed_nx;
				cry_elapsed_q  <= cry_elapsed_nx;
				buzz_elapsed_q <= buzz_elapsed_nx;
				hot_q          <= hot_nx;
				cold_q         <= cold_nx;
				cry_q          <= cry_nx;
				buzz_q         <= buzz_nx;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload; the cry, hot and cold flags and the buzzer level come straight
	// from the state flops, which change only when a new result is loaded.
	always_ff @(posedge clk) begin
		if (advance) begin
			pulse_q       <= pulse;
			pulse_alert_q <= pulse_hi;
			half_q        <= half;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, buzz_q, half_q, cold_q, hot_q, cry_q,
		pulse_alert_q, pulse_q};

endmodule
